>>> sv/pdec_pkg.sv
// ---------------------------------------------------------------------------
// pdec_pkg: shared types and constants of the percent decoder
// Result item layout, decode bundle and character codes.
// ---------------------------------------------------------------------------
package pdec_pkg;

    // Result slots one input byte can produce
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;

    // Error handling modes; the unused code behaves as keep
    localparam logic [1:0] MODE_STRICT  = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_KEEP    = 2'd2;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
        logic       error;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        result_t [MAX_RES-1:0]     ent;
    } decode_t;

endpackage

>>> sv/percent_decoder_unit.sv
// ---------------------------------------------------------------------------
// percent_decoder_unit: streaming URL percent decoder
// Decodes '+' and %XX escapes from a byte stream, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one raw byte per item, s_tlast on the last byte of a
//   string. Output channel m_*: decoded bytes; m_tlast marks the last result
//   caused by one input byte, m_tuser carries string end and error flags.
//   Config channel cfg_*: writes the error mode (strict, replace, keep); it
//   is always ready and should only be written while the block is idle.
// Path: an accepted item waits in the input register and moves to the
//   result buffer, whose head drives m_*, once that buffer is free.
// Throughput: one item per cycle while each byte yields at most one result
//   and m_tready is high. A byte that yields several results (up to three,
//   only in keep mode) holds the input register until the result buffer,
//   which drains one item per cycle while m_tready is high, hands out its last.
// Reset: clears the escape state, the input valid flag and result count, and the mode (strict).
// Stall: while m_tready is low the current result holds; s_tready drops once
//   the input register holds an item that the result buffer cannot take.
// ---------------------------------------------------------------------------
module percent_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // in_last
    // Result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser,    // [0] string_end, [1] error
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data    // err_mode
);

    logic [1:0]                 err_mode_reg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    pdec_pkg::result_t          buf_reg [pdec_pkg::MAX_RES];
    logic [pdec_pkg::CNT_W-1:0] cnt_reg;
    pdec_pkg::decode_t          dec;
    logic                       s_fire;
    logic                       m_fire;
    logic                       buf_free;
    logic                       advance;

    assign cfg_ready = 1'b1;

    // Handshakes
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == pdec_pkg::CNT_W'(1)) && m_fire);
    assign advance  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || advance;

    pdec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_byte (in_byte_reg),
        .item_last (in_last_reg),
        .mode      (err_mode_reg),
        .advance   (advance),
        .dec       (dec)
    );

    // Hold the error mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            err_mode_reg <= pdec_pkg::MODE_STRICT;
        end else if (cfg_valid && cfg_ready) begin
            err_mode_reg <= cfg_data;
        end
    end

    // Input register valid and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                cnt_reg <= dec.cnt;
            end else if (m_fire) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Input payload loads on accept; result payload loads on advance, shifts down on each taken item
    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            for (int k = 0; k < pdec_pkg::MAX_RES; k++) begin
                buf_reg[k] <= dec.ent[k];
            end
        end else if (m_fire) begin
            for (int k = 0; k < pdec_pkg::MAX_RES - 1; k++) begin
                buf_reg[k] <= buf_reg[k+1];
            end
        end
    end

    // Present the head of the result buffer
    assign m_tvalid   = (cnt_reg != '0);
    assign m_tdata    = buf_reg[0].data;
    assign m_tlast    = buf_reg[0].run_last;
    assign m_tuser[0] = buf_reg[0].string_end;
    assign m_tuser[1] = buf_reg[0].error;

endmodule

>>> sv/pdec_core.sv
// ---------------------------------------------------------------------------
// pdec_core: escape state and per-byte decode logic
// Holds the escape phase, the held digit and the drop flag, and turns one
// input byte into its list of up to three result items.
// ---------------------------------------------------------------------------
module pdec_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          item_byte,
    input  logic                item_last,
    input  logic [1:0]          mode,
    input  logic                advance,
    output pdec_pkg::decode_t   dec
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic [7:0]                 held_reg;
    logic [7:0]                 held_next;
    logic                       drop_reg;
    logic                       drop_next;

    logic [7:0]                 res [pdec_pkg::MAX_RES];
    logic [pdec_pkg::CNT_W-1:0] cnt;
    logic                       err;
    logic [4:0]                 hi_dig;
    logic [4:0]                 lo_dig;

    // Map '+' to space
    function automatic logic [7:0] xlate(input logic [7:0] c);
        return (c == pdec_pkg::PLUS_CHAR) ? pdec_pkg::SPACE_CHAR : c;
    endfunction

    // Hex digit value with a valid flag in the top bit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign hi_dig = hex_val(held_reg);
    assign lo_dig = hex_val(item_byte);

    // Decode one byte: emit results and work out the next escape state
    always_comb
    begin
        for (int k = 0; k < pdec_pkg::MAX_RES; k++) begin
            res[k] = 8'd0;
        end
        cnt        = '0;
        err        = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        drop_next  = drop_reg;

        if (drop_reg) begin
            drop_next = !item_last;
        end else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item_byte == pdec_pkg::PCT_CHAR) begin
                        phase_next = PH_PCT;
                    end else begin
                        res[cnt] = xlate(item_byte);
                        cnt      = cnt + 1'b1;
                    end
                end
                PH_PCT:
                begin
                    held_next  = item_byte;
                    phase_next = PH_DIGIT;
                end
                PH_DIGIT:
                begin
                    phase_next = PH_IDLE;
                    if (hi_dig[4] && lo_dig[4]) begin
                        res[cnt] = {hi_dig[3:0], lo_dig[3:0]};
                        cnt      = cnt + 1'b1;
                    end else begin
                        case (mode)
                            pdec_pkg::MODE_STRICT:
                            begin
                                err = 1'b1;
                            end
                            pdec_pkg::MODE_REPLACE:
                            begin
                                res[cnt] = pdec_pkg::QMARK_CHAR;
                                cnt      = cnt + 1'b1;
                            end
                            default:
                            begin
                                // Keep the '%' and rescan the two bytes after it
                                res[cnt] = pdec_pkg::PCT_CHAR;
                                cnt      = cnt + 1'b1;
                                if (held_reg == pdec_pkg::PCT_CHAR) begin
                                    phase_next = PH_DIGIT;
                                    held_next  = item_byte;
                                end else begin
                                    res[cnt] = xlate(held_reg);
                                    cnt      = cnt + 1'b1;
                                    if (item_byte == pdec_pkg::PCT_CHAR) begin
                                        phase_next = PH_PCT;
                                    end else begin
                                        res[cnt] = xlate(item_byte);
                                        cnt      = cnt + 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Close an open escape at the end of the string
            if (item_last && !err) begin
                case (phase_next)
                    PH_PCT:
                    begin
                        if (mode == pdec_pkg::MODE_STRICT) begin
                            err = 1'b1;
                        end else begin
                            res[cnt] = (mode == pdec_pkg::MODE_REPLACE) ?
                                       pdec_pkg::QMARK_CHAR : pdec_pkg::PCT_CHAR;
                            cnt      = cnt + 1'b1;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (mode == pdec_pkg::MODE_STRICT) begin
                            err = 1'b1;
                        end else if (mode == pdec_pkg::MODE_REPLACE) begin
                            res[cnt] = pdec_pkg::QMARK_CHAR;
                            cnt      = cnt + 1'b1;
                        end else begin
                            res[cnt] = pdec_pkg::PCT_CHAR;
                            cnt      = cnt + 1'b1;
                            res[cnt] = (held_next == pdec_pkg::PCT_CHAR) ?
                                       pdec_pkg::PCT_CHAR : xlate(held_next);
                            cnt      = cnt + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                phase_next = PH_IDLE;
            end

            // Reject the string and drop the rest of it
            if (err) begin
                phase_next = PH_IDLE;
                held_next  = 8'd0;
                drop_next  = !item_last;
            end
        end
    end

    // Build the result list
    always_comb
    begin
        if (err) begin
            dec.cnt = pdec_pkg::CNT_W'(1);
            dec.ent = '0;
            dec.ent[0].run_last   = 1'b1;
            dec.ent[0].string_end = 1'b1;
            dec.ent[0].error      = 1'b1;
        end else begin
            dec.cnt = cnt;
            for (int k = 0; k < pdec_pkg::MAX_RES; k++) begin
                dec.ent[k].data       = res[k];
                dec.ent[k].run_last   = (pdec_pkg::CNT_W'(k + 1) == cnt);
                dec.ent[k].string_end = (pdec_pkg::CNT_W'(k + 1) == cnt) && item_last;
                dec.ent[k].error      = 1'b0;
            end
        end
    end

    // Hold escape state; advance when the byte moves to the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
            drop_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

>>> sv/pdec_checker.sv
// ---------------------------------------------------------------------------
// pdec_checker: port-level checks of the percent decoder
// Watches the result channel and is bound to the top level.
// ---------------------------------------------------------------------------
module pdec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // An error item closes the string and carries a zero byte
    a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0] && m_tdata == 8'd0))
        else $error("error item does not close the string");

    // String end is always the last result of its input byte
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("string end without run last");

    // A valid result carries known fields
    a_known_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
        else $error("unknown result field");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
        $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind percent_decoder_unit pdec_checker u_pdec_checker (.*);
